// ===== sv/lap_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the five-point Laplacian stencil.
// Depends on nothing; the top module, the front end and the back end import it.

package lap_pkg;

    // Configuration port geometry and register reset values.
    localparam int unsigned CFG_DATA_BITS   = 16;
    localparam int unsigned CFG_IDX_BITS    = 1;
    localparam int unsigned WIDTH_REG_BITS  = 13;
    localparam int unsigned HEIGHT_REG_BITS = 16;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 13'd4096;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd4096;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // Position class of one pixel, worked out by the front end.
    typedef struct packed {
        logic row_ge1;   // row index at least one
        logic row_ge2;   // row index at least two
        logic col_gt0;   // column index above zero
        logic col_ge2;   // column index at least two
        logic last_col;  // last column of the row
        logic last_row;  // last row of the frame
    } t_pos;

    localparam int unsigned POS_BITS = $bits(t_pos);

    // Result slots one pixel can cause, in delivery order.
    localparam int unsigned RES_COUNT = 3;
    localparam int unsigned RES_ABOVE = 0;  // pixel of the row above, same column
    localparam int unsigned RES_LEFT  = 1;  // last row, pixel to the left
    localparam int unsigned RES_SELF  = 2;  // last pixel of the frame itself

endpackage

// ===== sv/lap_pix_if.sv =====
`timescale 1ns / 1ps
// Input channel of the Laplacian stencil: one pixel per beat.
// Depends on nothing.

interface lap_pix_if #(
    parameter int unsigned PIX_BITS = 16
) ();
    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/lap_res_if.sv =====
`timescale 1ns / 1ps
// Output channel of the Laplacian stencil: one result per beat.
// Depends on nothing.

interface lap_res_if #(
    parameter int unsigned LAP_BITS = 19
) ();
    logic                       valid;
    logic                       ready;
    logic signed [LAP_BITS-1:0] laplacian;
    logic                       last_of_run;
    logic                       frame_done;

    modport source (output valid, output laplacian, output last_of_run,
                    output frame_done, input ready);
    modport sink   (input valid, input laplacian, input last_of_run,
                    input frame_done, output ready);
endinterface

// ===== sv/image_laplacian_stencil.sv =====
`timescale 1ns / 1ps
// Streaming five-point Laplacian: pixels enter in raster order, one per beat, and
// each result is the sum of neighbor-minus-center over left, right, up and down,
// with terms for neighbors outside the frame left out. The result for a pixel of
// row j-1 leaves when the pixel below it arrives; on the last row each pixel
// also releases its left neighbor and the final pixel its own result, flagged by
// frame_done, with last_of_run on the final result of each pixel. The block takes
// one pixel per clock unless the queue is full; the output delivers one result
// per clock unless held by o_res.ready, so on the last row, past its first pixel,
// each pixel releases two results (three for the final pixel) and input slows.
// One row buffer RAM of MAX_WIDTH entries, two samples wide, holds the two
// previous rows and is read one column ahead of the pixel; it needs no clearing
// pass after reset. A write to frame_width or frame_height restarts the frame; the
// user makes it only while idle, which the block itself does not enforce.

module image_laplacian_stencil #(
    parameter int unsigned MAX_WIDTH   = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  lap_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [lap_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    lap_pix_if.sink                           i_pix,
    lap_res_if.source                         o_res
);
    import lap_pkg::*;

    localparam int unsigned COL_BITS  = $clog2(MAX_WIDTH);
    localparam int unsigned ITEM_BITS = SAMPLE_BITS + 2 * COL_BITS + POS_BITS;

    logic                   f_push;
    logic [SAMPLE_BITS-1:0] f_pixel;
    logic [COL_BITS-1:0]    f_col;
    logic [COL_BITS-1:0]    f_rd_addr;
    t_pos                   f_pos;
    logic [ITEM_BITS-1:0]   q_in;
    logic [ITEM_BITS-1:0]   q_out;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;

    // Front end: configuration, position counters, classification.
    lap_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_full   (q_full),
        .o_push     (f_push),
        .o_pixel    (f_pixel),
        .o_col      (f_col),
        .o_rd_addr  (f_rd_addr),
        .o_pos      (f_pos)
    );

    // Queue between the two halves.
    assign q_in = {f_pixel, f_col, f_rd_addr, f_pos};

    lap_fifo #(
        .DATA_BITS (ITEM_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: row buffer, stencil sums, output register.
    lap_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!q_empty),
        .i_q_pixel   (q_out[ITEM_BITS-1 -: SAMPLE_BITS]),
        .i_q_col     (q_out[POS_BITS + 2 * COL_BITS - 1 -: COL_BITS]),
        .i_q_rd_addr (q_out[POS_BITS + COL_BITS - 1 -: COL_BITS]),
        .i_q_pos     (t_pos'(q_out[POS_BITS-1:0])),
        .o_pop       (q_pop),
        .o_res       (o_res)
    );
endmodule

// ===== sv/lap_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.

module lap_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/lap_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue that decouples the stencil front end from the back end.
// Depends on nothing.

module lap_fifo #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_data,
    output logic                 o_full,
    output logic                 o_empty
);
    logic [DATA_BITS-1:0] r_mem [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = r_cnt[1];
    assign o_empty = (r_cnt == 2'd0);
endmodule

// ===== sv/lap_front.sv =====
`timescale 1ns / 1ps
// Front end of the stencil: configuration registers, raster position counters
// and classification of each accepted pixel. Uses lap_pkg and lap_pix_if.

module lap_front #(
    parameter int unsigned MAX_WIDTH   = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  lap_pkg::t_cfg_idx                     i_cfg_idx,
    input  logic [lap_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    lap_pix_if.sink                               i_pix,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output logic [SAMPLE_BITS-1:0]                o_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]          o_col,
    output logic [$clog2(MAX_WIDTH)-1:0]          o_rd_addr,
    output lap_pkg::t_pos                         o_pos
);
    import lap_pkg::*;

    localparam int unsigned COL_BITS = $clog2(MAX_WIDTH);
    localparam logic [31:0] MaxW     = 32'(MAX_WIDTH);

    logic [WIDTH_REG_BITS-1:0]  r_width;
    logic [HEIGHT_REG_BITS-1:0] r_height;
    logic [COL_BITS-1:0]        r_col;
    logic [COL_BITS-1:0]        n_col;
    logic [HEIGHT_REG_BITS-1:0] r_row;
    logic [HEIGHT_REG_BITS-1:0] n_row;
    logic [COL_BITS-1:0]        last_col_idx;
    logic [HEIGHT_REG_BITS-1:0] last_row_idx;
    logic [31:0]                width_ext;
    t_pos                       pos;
    logic                       accept;

    // Effective frame limits: zero acts as one, width clamps to the buffer depth.
    always_comb begin
        width_ext = 32'(r_width);
        if (r_width == '0) begin
            last_col_idx = '0;
        end else if (width_ext > MaxW) begin
            last_col_idx = COL_BITS'(MaxW - 32'd1);
        end else begin
            last_col_idx = COL_BITS'(width_ext - 32'd1);
        end
        last_row_idx = (r_height == '0) ? '0 : r_height - 16'd1;
    end

    // Classify the current raster position.
    always_comb begin
        pos.row_ge1  = (r_row != '0);
        pos.row_ge2  = (r_row > 16'd1);
        pos.col_gt0  = (r_col != '0);
        pos.col_ge2  = (r_col > COL_BITS'(1));
        pos.last_col = (r_col == last_col_idx);
        pos.last_row = (r_row == last_row_idx);
    end

    // Next raster position; a frame wraps back to its origin.
    always_comb begin
        if (pos.last_col) begin
            n_col = '0;
            n_row = pos.last_row ? '0 : r_row + 16'd1;
        end else begin
            n_col = r_col + COL_BITS'(1);
            n_row = r_row;
        end
    end

    assign accept      = i_pix.valid && !i_q_full;
    assign i_pix.ready = !i_q_full;

    // Configuration registers and position counters; any write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_BITS-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_BITS-1:0];
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // The buffer entry one column ahead is fetched with each pixel; the last
    // column fetches column zero for the start of the next row.
    assign o_push    = accept;
    assign o_pixel   = i_pix.pixel;
    assign o_col     = r_col;
    assign o_rd_addr = pos.last_col ? '0 : r_col + COL_BITS'(1);
    assign o_pos     = pos;
endmodule

// ===== sv/lap_back.sv =====
`timescale 1ns / 1ps
// Back end of the stencil: row buffer, neighbor window, Laplacian sums and
// the output register. Uses lap_pkg, lap_ram and lap_res_if.

module lap_back #(
    parameter int unsigned MAX_WIDTH   = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic [SAMPLE_BITS-1:0]       i_q_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_q_col,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_q_rd_addr,
    input  lap_pkg::t_pos                i_q_pos,
    output logic                         o_pop,
    lap_res_if.source                    o_res
);
    import lap_pkg::*;

    localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH);
    localparam int unsigned OUT_BITS   = SAMPLE_BITS + 3;
    localparam int unsigned ENTRY_BITS = 2 * SAMPLE_BITS;
    localparam logic signed [OUT_BITS-1:0] Zero = '0;

    // Difference of two samples, widened to the result width.
    function automatic logic signed [OUT_BITS-1:0] diff(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b
    );
        return $signed(OUT_BITS'(a)) - $signed(OUT_BITS'(b));
    endfunction

    // Pixel in work and its window.
    logic                       r_b_valid;
    logic [SAMPLE_BITS-1:0]     r_b_pix;
    logic [COL_BITS-1:0]        r_b_col;
    t_pos                       r_b_pos;
    logic                       r_fwd_hit;
    logic [ENTRY_BITS-1:0]      r_fwd_entry;
    logic [ENTRY_BITS-1:0]      r_c_entry;
    logic [SAMPLE_BITS-1:0]     r_nl;
    logic [SAMPLE_BITS-1:0]     r_pp;
    logic [SAMPLE_BITS-1:0]     r_ppp;
    logic [RES_COUNT-1:0]       r_sent;

    // Output register.
    logic                       r_o_valid;
    logic signed [OUT_BITS-1:0] r_o_lap;
    logic                       r_o_last;
    logic                       r_o_done;

    logic [ENTRY_BITS-1:0]      ram_rdata;
    logic [ENTRY_BITS-1:0]      right_entry;
    logic [ENTRY_BITS-1:0]      wr_entry;
    logic [SAMPLE_BITS-1:0]     nc;
    logic [SAMPLE_BITS-1:0]     oc;
    logic [SAMPLE_BITS-1:0]     nr;
    logic signed [OUT_BITS-1:0] res_above;
    logic signed [OUT_BITS-1:0] res_left;
    logic signed [OUT_BITS-1:0] res_self;
    logic signed [OUT_BITS-1:0] sel_lap;
    logic [RES_COUNT-1:0]       mask;
    logic [RES_COUNT-1:0]       pending;
    logic [RES_COUNT-1:0]       pick;
    logic                       is_last;
    logic                       out_load;
    logic                       emit;
    logic                       leave;
    logic                       pop;

    // Each buffer entry holds the newer row in its upper half, the older below.
    lap_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_buf (
        .i_clk   (i_clk),
        .i_we    (leave),
        .i_waddr (r_b_col),
        .i_wdata (wr_entry),
        .i_re    (pop),
        .i_raddr (i_q_rd_addr),
        .o_rdata (ram_rdata)
    );

    // Window values: a write that lands on the entry being fetched is forwarded.
    always_comb begin
        right_entry = r_fwd_hit ? r_fwd_entry : ram_rdata;
        nr          = right_entry[ENTRY_BITS-1 -: SAMPLE_BITS];
        nc          = r_c_entry[ENTRY_BITS-1 -: SAMPLE_BITS];
        oc          = r_c_entry[SAMPLE_BITS-1:0];
        wr_entry    = {r_b_pix, nc};
    end

    // The three candidate results of the pixel in work.
    always_comb begin
        res_above = diff(r_b_pix, nc)
                  + (r_b_pos.col_gt0  ? diff(r_nl, nc) : Zero)
                  + (!r_b_pos.last_col ? diff(nr, nc)   : Zero)
                  + (r_b_pos.row_ge2  ? diff(oc, nc)   : Zero);
        res_left  = diff(r_b_pix, r_pp)
                  + (r_b_pos.col_ge2 ? diff(r_ppp, r_pp) : Zero)
                  + (r_b_pos.row_ge1 ? diff(r_nl, r_pp)  : Zero);
        res_self  = (r_b_pos.col_gt0 ? diff(r_pp, r_b_pix) : Zero)
                  + (r_b_pos.row_ge1 ? diff(nc, r_b_pix)   : Zero);
    end

    // Pick the next result still owed, in delivery order.
    always_comb begin
        mask            = '0;
        mask[RES_ABOVE] = r_b_pos.row_ge1;
        mask[RES_LEFT]  = r_b_pos.last_row && r_b_pos.col_gt0;
        mask[RES_SELF]  = r_b_pos.last_row && r_b_pos.last_col;
        pending         = mask & ~r_sent;
        pick            = pending & (~pending + RES_COUNT'(1));
        is_last         = ((pending & (pending - RES_COUNT'(1))) == '0);
        if (pick[RES_ABOVE]) begin
            sel_lap = res_above;
        end else if (pick[RES_LEFT]) begin
            sel_lap = res_left;
        end else begin
            sel_lap = res_self;
        end
    end

    // Flow control between the queue, the work stage and the output register.
    assign out_load = !r_o_valid || o_res.ready;
    assign emit     = r_b_valid && (pending != '0) && out_load;
    assign leave    = r_b_valid && ((pending == '0) || (emit && is_last));
    assign pop      = i_q_valid && (!r_b_valid || leave);
    assign o_pop    = pop;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_sent    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_b_valid <= 1'b1;
            end else if (leave) begin
                r_b_valid <= 1'b0;
            end
            if (leave) begin
                r_sent <= '0;
            end else if (emit) begin
                r_sent <= r_sent | pick;
            end
            if (out_load) begin
                r_o_valid <= emit;
            end
        end
    end

    // Load the next pixel; note a concurrent write to the entry being fetched.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b_pix     <= i_q_pixel;
            r_b_col     <= i_q_col;
            r_b_pos     <= i_q_pos;
            r_fwd_hit   <= leave && (r_b_col == i_q_rd_addr);
            r_fwd_entry <= wr_entry;
        end
    end

    // Slide the window when a pixel retires. With a one-pixel row the next
    // center is the entry this pixel has just written.
    always_ff @(posedge i_clk) begin
        if (leave) begin
            r_c_entry <= (r_b_pos.last_col && !r_b_pos.col_gt0) ? wr_entry : right_entry;
            r_nl      <= nc;
            r_pp      <= r_b_pix;
            r_ppp     <= r_pp;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_lap  <= sel_lap;
            r_o_last <= is_last;
            r_o_done <= pick[RES_SELF];
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.laplacian   = r_o_lap;
    assign o_res.last_of_run = r_o_last;
    assign o_res.frame_done  = r_o_done;
endmodule
